[rtl/state_change_rate_classifier_assert.svh]
// assertion macros for the checker file
`ifndef STATE_CHANGE_RATE_CLASSIFIER_ASSERT_SVH
`define STATE_CHANGE_RATE_CLASSIFIER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SCRC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scrc check failed");

// next-cycle implication, sampled on clk, off during reset
`define SCRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scrc check failed");

`endif

[rtl/scrc_pkg.sv]
`timescale 1ns / 1ps
package scrc_pkg;
	localparam int ELEM_W    = 16;
	localparam int NORM_W    = 20;
	localparam int WEIGHT_W  = 9;
	localparam int PAT_W     = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [NORM_W-1:0] NORM_MAX = 20'hFFFFF;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW  = 2'd2;

	localparam logic [NORM_W-1:0] HIGH_RST = 20'd2048;
	localparam logic [NORM_W-1:0] MOD_RST  = 20'd1229;
	localparam logic [NORM_W-1:0] LOW_RST  = 20'd410;

	// attention patterns and weights
	localparam logic [PAT_W-1:0] PAT_DENSE   = 2'd0;
	localparam logic [PAT_W-1:0] PAT_LOCAL   = 2'd1;
	localparam logic [PAT_W-1:0] PAT_STRIDED = 2'd2;
	localparam logic [PAT_W-1:0] PAT_SPARSE  = 2'd3;

	localparam logic [WEIGHT_W-1:0] WGT_DENSE   = 9'd256;
	localparam logic [WEIGHT_W-1:0] WGT_LOCAL   = 9'd205;
	localparam logic [WEIGHT_W-1:0] WGT_STRIDED = 9'd128;
	localparam logic [WEIGHT_W-1:0] WGT_SPARSE  = 9'd51;
	localparam logic [WEIGHT_W-1:0] WGT_FIRST   = 9'd256;

	// datapath operations
	typedef logic [3:0] op_t;
	localparam op_t OP_NONE     = 4'd0;
	localparam op_t OP_LOAD     = 4'd1;
	localparam op_t OP_ACCUM    = 4'd2;
	localparam op_t OP_GET_RATE = 4'd3;
	localparam op_t OP_GET_MAG  = 4'd4;
	localparam op_t OP_VOL_ZERO = 4'd5;
	localparam op_t OP_MUL      = 4'd6;
	localparam op_t OP_SPREAD   = 4'd7;
	localparam op_t OP_GET_VOL  = 4'd8;
	localparam op_t OP_RING_RD  = 4'd9;
	localparam op_t OP_PUSH     = 4'd10;
	localparam op_t OP_EMIT     = 4'd11;

	// square root operand sources
	typedef logic [1:0] sq_src_t;
	localparam sq_src_t SRC_DIFF   = 2'd0;
	localparam sq_src_t SRC_VALUE  = 2'd1;
	localparam sq_src_t SRC_SPREAD = 2'd2;

	typedef struct packed {
		op_t     op;
		logic    sq_start;
		sq_src_t sq_src;
		logic    div_start;
	} dp_cmd_t;

	typedef struct packed {
		logic has_prev;
		logic few_hist;
		logic last;
		logic sq_busy;
		logic div_busy;
		logic out_free;
	} dp_stat_t;
endpackage

[rtl/scrc_sqrt.sv]
`timescale 1ns / 1ps
module scrc_sqrt #(
	parameter int W = 60
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   din,
	output logic           busy,
	output logic [W/2-1:0] root
);
	localparam int RW = W / 2;
	localparam int KW = $clog2(RW + 1);

	logic [W-1:0]  val_q;
	logic [RW+1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic [RW+1:0] rem_n;
	logic [RW+1:0] trial;
	logic          take;

	// one result bit per cycle, bit pairs from the top
	assign rem_n = {rem_q[RW-1:0], val_q[W-1:W-2]};
	assign trial = {root_q, 2'b01};
	assign take  = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= KW'(RW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - KW'(1);
			busy_q <= cnt_q != KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= din;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[W-3:0], 2'b00};
			rem_q  <= take ? rem_n - trial : rem_n;
			root_q <= {root_q[RW-2:0], take};
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule

[rtl/scrc_div.sv]
`timescale 1ns / 1ps
module scrc_div #(
	parameter int NW = 30,
	parameter int DW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo
);
	localparam int KW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   rem_n;
	logic          take;

	// restoring division, one quotient bit per cycle
	assign rem_n = {rem_q[DW-1:0], quo_q[NW-1]};
	assign take  = rem_n >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= KW'(NW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - KW'(1);
			busy_q <= cnt_q != KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? rem_n - {1'b0, den_q} : rem_n;
			quo_q <= {quo_q[NW-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule

[rtl/scrc_datapath.sv]
`timescale 1ns / 1ps
module scrc_datapath import scrc_pkg::*; #(
	parameter int VECTOR_MAX    = 256,
	parameter int HISTORY_DEPTH = 1000
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_stat_t                   stat,
	input  logic signed [ELEM_W-1:0]   state_element,
	input  logic                       vector_end,
	input  logic                       cfg_valid,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [NORM_W-1:0]          cfg_data,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [NORM_W-1:0]          diff_norm,
	output logic [NORM_W-1:0]          magnitude,
	output logic [NORM_W-1:0]          volatility,
	output logic                       transition,
	output logic [PAT_W-1:0]           pattern,
	output logic [WEIGHT_W-1:0]        weight
);
	localparam int AW   = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1;
	localparam int IW   = $clog2(VECTOR_MAX + 1);
	localparam int DSW  = 2 * ELEM_W + 2 + AW;
	localparam int VSW  = 2 * ELEM_W + AW;
	localparam int CW   = $clog2(HISTORY_DEPTH + 1);
	localparam int HW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HSW  = NORM_W + CW;
	localparam int HQW  = 2 * NORM_W + CW;
	localparam int HL   = HQW / 2;
	localparam int HH   = HQW - HL;
	localparam int SPW  = CW + HQW;
	localparam int SW0  = (DSW > SPW) ? DSW : SPW;
	localparam int SW   = SW0 + (SW0 % 2);
	localparam int RW   = SW / 2;

	// stores
	logic signed [ELEM_W-1:0] prev_mem [VECTOR_MAX];
	logic [NORM_W-1:0]        ring_mem [HISTORY_DEPTH];

	// control state
	logic [IW-1:0]   idx_q;
	logic [DSW-1:0]  dsum_q;
	logic [VSW-1:0]  vsum_q;
	logic            have_prev_q;
	logic [HW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [HSW-1:0]  hsum_q;
	logic [HQW-1:0]  hsq_q;
	logic            out_valid_q;
	logic [NORM_W-1:0] high_q, mod_q, low_q;

	// payload
	logic signed [ELEM_W-1:0] elem_q;
	logic signed [ELEM_W-1:0] prev_rd_q;
	logic                     last_q;
	logic [NORM_W-1:0]        rate_q, mag_q, vol_q, old_q;
	logic [CW+HL-1:0]         plo_q;
	logic [CW+HH-1:0]         phi_q;
	logic [SPW-1:0]           s2_q;
	logic [SPW-1:0]           spread_q;
	logic [NORM_W-1:0]        rate_o_q, mag_o_q, vol_o_q;
	logic                     trans_o_q;
	logic [PAT_W-1:0]         pat_o_q;
	logic [WEIGHT_W-1:0]      wgt_o_q;

	// element arithmetic
	logic signed [ELEM_W:0]   d;
	logic signed [ELEM_W:0]   dn;
	logic signed [ELEM_W:0]   en;
	logic [ELEM_W-1:0]        ad, ae;
	logic [2*ELEM_W-1:0]      dsq, esq;
	logic                     in_range;

	// shared units
	logic [SW-1:0]   sq_din;
	logic            sq_busy;
	logic [RW-1:0]   sq_root;
	logic            div_busy;
	logic [RW-1:0]   div_quo;
	logic [NORM_W-1:0] root_sat;

	// history update
	logic [2*NORM_W-1:0] r2, o2;
	logic                full;
	logic                out_free;

	assign in_range = idx_q < IW'(VECTOR_MAX);
	assign d   = (ELEM_W+1)'(elem_q) - (ELEM_W+1)'(prev_rd_q);
	assign dn  = -d;
	assign en  = -((ELEM_W+1)'(elem_q));
	assign ad  = d[ELEM_W] ? dn[ELEM_W-1:0] : d[ELEM_W-1:0];
	assign ae  = elem_q[ELEM_W-1] ? en[ELEM_W-1:0] : elem_q[ELEM_W-1:0];
	assign dsq = (2*ELEM_W)'(ad) * (2*ELEM_W)'(ad);
	assign esq = (2*ELEM_W)'(ae) * (2*ELEM_W)'(ae);

	assign r2   = (2*NORM_W)'(rate_q) * (2*NORM_W)'(rate_q);
	assign o2   = (2*NORM_W)'(old_q) * (2*NORM_W)'(old_q);
	assign full = count_q == CW'(HISTORY_DEPTH);

	assign out_free = !out_valid_q || out_ready;

	// square root operand select
	always_comb begin
		unique case (cmd.sq_src)
			SRC_DIFF:   sq_din = SW'(dsum_q);
			SRC_VALUE:  sq_din = SW'(vsum_q);
			SRC_SPREAD: sq_din = SW'(spread_q);
			default:    sq_din = '0;
		endcase
	end

	assign root_sat = (sq_root > RW'(NORM_MAX)) ? NORM_MAX : sq_root[NORM_W-1:0];

	scrc_sqrt #(.W(SW)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sq_start),
		.din    (sq_din),
		.busy   (sq_busy),
		.root   (sq_root)
	);

	scrc_div #(.NW(RW), .DW(CW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (sq_root),
		.den    (count_q),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// previous vector store
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD)
			prev_rd_q <= prev_mem[idx_q[AW-1:0]];
		if (cmd.op == OP_ACCUM && in_range)
			prev_mem[idx_q[AW-1:0]] <= elem_q;
	end

	// change rate history store
	always_ff @(posedge clk) begin
		if (cmd.op == OP_RING_RD)
			old_q <= ring_mem[head_q];
		if (cmd.op == OP_PUSH)
			ring_mem[head_q] <= rate_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= HIGH_RST;
			mod_q  <= MOD_RST;
			low_q  <= LOW_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_HIGH)
				high_q <= cfg_data;
			if (cfg_index == REG_MOD)
				mod_q <= cfg_data;
			if (cfg_index == REG_LOW)
				low_q <= cfg_data;
		end
	end

	// sums, history bookkeeping and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			dsum_q      <= '0;
			vsum_q      <= '0;
			have_prev_q <= 1'b0;
			head_q      <= '0;
			count_q     <= '0;
			hsum_q      <= '0;
			hsq_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_EMIT)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (cmd.op)
				OP_ACCUM: begin
					if (in_range) begin
						dsum_q <= dsum_q + DSW'(dsq);
						vsum_q <= vsum_q + VSW'(esq);
						idx_q  <= idx_q + IW'(1);
					end
				end
				OP_PUSH: begin
					if (full) begin
						hsum_q <= hsum_q - HSW'(old_q) + HSW'(rate_q);
						hsq_q  <= hsq_q - HQW'(o2) + HQW'(r2);
					end else begin
						hsum_q  <= hsum_q + HSW'(rate_q);
						hsq_q   <= hsq_q + HQW'(r2);
						count_q <= count_q + CW'(1);
					end
					head_q <= (head_q == HW'(HISTORY_DEPTH - 1)) ? '0 : head_q + HW'(1);
				end
				OP_EMIT: begin
					have_prev_q <= 1'b1;
					idx_q       <= '0;
					dsum_q      <= '0;
					vsum_q      <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// working and output payload registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				elem_q <= state_element;
				last_q <= vector_end;
			end
			OP_GET_RATE: rate_q <= root_sat;
			OP_GET_MAG:  mag_q  <= root_sat;
			OP_VOL_ZERO: vol_q  <= '0;
			OP_MUL: begin
				plo_q <= (CW+HL)'(count_q) * (CW+HL)'(hsq_q[HL-1:0]);
				phi_q <= (CW+HH)'(count_q) * (CW+HH)'(hsq_q[HQW-1:HL]);
				s2_q  <= SPW'(hsum_q) * SPW'(hsum_q);
			end
			OP_SPREAD: spread_q <= (SPW'(phi_q) << HL) + SPW'(plo_q) - s2_q;
			OP_GET_VOL: vol_q <= div_quo[NORM_W-1:0];
			OP_EMIT: begin
				if (!have_prev_q) begin
					rate_o_q  <= '0;
					mag_o_q   <= '0;
					vol_o_q   <= '0;
					trans_o_q <= 1'b0;
					pat_o_q   <= PAT_SPARSE;
					wgt_o_q   <= WGT_FIRST;
				end else begin
					rate_o_q  <= rate_q;
					mag_o_q   <= mag_q;
					vol_o_q   <= vol_q;
					trans_o_q <= rate_q > high_q;
					priority if (rate_q > high_q) begin
						pat_o_q <= PAT_DENSE;
						wgt_o_q <= WGT_DENSE;
					end else if (rate_q > mod_q) begin
						pat_o_q <= PAT_LOCAL;
						wgt_o_q <= WGT_LOCAL;
					end else if (rate_q > low_q) begin
						pat_o_q <= PAT_STRIDED;
						wgt_o_q <= WGT_STRIDED;
					end else begin
						pat_o_q <= PAT_SPARSE;
						wgt_o_q <= WGT_SPARSE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.has_prev = have_prev_q;
	assign stat.few_hist = count_q < CW'(2);
	assign stat.last     = last_q;
	assign stat.sq_busy  = sq_busy;
	assign stat.div_busy = div_busy;
	assign stat.out_free = out_free;

	assign out_valid   = out_valid_q;
	assign diff_norm   = rate_o_q;
	assign magnitude   = mag_o_q;
	assign volatility  = vol_o_q;
	assign transition  = trans_o_q;
	assign pattern     = pat_o_q;
	assign weight      = wgt_o_q;
endmodule

[rtl/scrc_ctrl.sv]
`timescale 1ns / 1ps
module scrc_ctrl import scrc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ELEM   = 4'd1;
	localparam logic [3:0] S_CLOSE  = 4'd2;
	localparam logic [3:0] S_WRATE  = 4'd3;
	localparam logic [3:0] S_SQMAG  = 4'd4;
	localparam logic [3:0] S_WMAG   = 4'd5;
	localparam logic [3:0] S_VCHK   = 4'd6;
	localparam logic [3:0] S_SPREAD = 4'd7;
	localparam logic [3:0] S_SQVOL  = 4'd8;
	localparam logic [3:0] S_WVOL   = 4'd9;
	localparam logic [3:0] S_DIV    = 4'd10;
	localparam logic [3:0] S_WDIV   = 4'd11;
	localparam logic [3:0] S_RING   = 4'd12;
	localparam logic [3:0] S_PUSH   = 4'd13;
	localparam logic [3:0] S_OUT    = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// sequencing of element and vector end work
	always_comb begin
		state_d       = state_q;
		cmd.op        = OP_NONE;
		cmd.sq_start  = 1'b0;
		cmd.sq_src    = SRC_DIFF;
		cmd.div_start = 1'b0;
		in_ready      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_ELEM;
				end
			end
			S_ELEM: begin
				cmd.op  = OP_ACCUM;
				state_d = stat.last ? S_CLOSE : S_IDLE;
			end
			S_CLOSE: begin
				if (!stat.has_prev) begin
					state_d = S_OUT;
				end else begin
					cmd.sq_start = 1'b1;
					cmd.sq_src   = SRC_DIFF;
					state_d      = S_WRATE;
				end
			end
			S_WRATE: begin
				if (!stat.sq_busy) begin
					cmd.op  = OP_GET_RATE;
					state_d = S_SQMAG;
				end
			end
			S_SQMAG: begin
				cmd.sq_start = 1'b1;
				cmd.sq_src   = SRC_VALUE;
				state_d      = S_WMAG;
			end
			S_WMAG: begin
				if (!stat.sq_busy) begin
					cmd.op  = OP_GET_MAG;
					state_d = S_VCHK;
				end
			end
			S_VCHK: begin
				if (stat.few_hist) begin
					cmd.op  = OP_VOL_ZERO;
					state_d = S_RING;
				end else begin
					cmd.op  = OP_MUL;
					state_d = S_SPREAD;
				end
			end
			S_SPREAD: begin
				cmd.op  = OP_SPREAD;
				state_d = S_SQVOL;
			end
			S_SQVOL: begin
				cmd.sq_start = 1'b1;
				cmd.sq_src   = SRC_SPREAD;
				state_d      = S_WVOL;
			end
			S_WVOL: begin
				if (!stat.sq_busy)
					state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = S_WDIV;
			end
			S_WDIV: begin
				if (!stat.div_busy) begin
					cmd.op  = OP_GET_VOL;
					state_d = S_RING;
				end
			end
			S_RING: begin
				cmd.op  = OP_RING_RD;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				cmd.op  = OP_PUSH;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

[rtl/state_change_rate_classifier.sv]
`timescale 1ns / 1ps
// State change rate classifier. Elements of a state vector arrive one per transaction,
// with vector_end on the last one; each element is handled as a read of the stored
// previous element, then the square-and-accumulate step. At vector end one result
// transaction follows: change rate (diff_norm) and magnitude as integer square roots,
// volatility as the population standard deviation of earlier rates, and a pattern and
// weight picked against three threshold registers (indexes 0 high, 1 moderate, 2 low).
// The vector end work runs on one shared bit-serial square root unit (operand width
// 60 at the default parameters) and a bit-serial divider; when under two rates are
// stored volatility is zero and its steps are skipped, and for the first vector only
// the output step runs. A finished result waits in an output register while the next
// vector streams in. Threshold writes are always accepted.
module state_change_rate_classifier import scrc_pkg::*; #(
	parameter int VECTOR_MAX    = 256,
	parameter int HISTORY_DEPTH = 1000
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [ELEM_W-1:0] state_element,
	input  logic                     vector_end,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [NORM_W-1:0]        diff_norm,
	output logic [NORM_W-1:0]        magnitude,
	output logic [NORM_W-1:0]        volatility,
	output logic                     transition,
	output logic [PAT_W-1:0]         pattern,
	output logic [WEIGHT_W-1:0]      weight,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [NORM_W-1:0]        cfg_data
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// threshold writes never stall
	assign cfg_ready = 1'b1;

	scrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	scrc_datapath #(
		.VECTOR_MAX    (VECTOR_MAX),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.state_element (state_element),
		.vector_end    (vector_end),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.diff_norm     (diff_norm),
		.magnitude     (magnitude),
		.volatility    (volatility),
		.transition    (transition),
		.pattern       (pattern),
		.weight        (weight)
	);
endmodule

[rtl/scrc_checker.sv]
`timescale 1ns / 1ps
`include "state_change_rate_classifier_assert.svh"
module scrc_sva import scrc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [NORM_W-1:0]   diff_norm,
	input logic [NORM_W-1:0]   volatility,
	input logic                transition,
	input logic [PAT_W-1:0]    pattern,
	input logic [WEIGHT_W-1:0] weight
);
	// a stalled result holds
	`SCRC_ASSERT_NEXT(a_rate_hold, out_valid && !out_ready, out_valid && $stable(diff_norm))
	`SCRC_ASSERT_NEXT(a_vol_hold, out_valid && !out_ready, $stable(volatility))
	// a transition always means the dense pattern at full weight
	`SCRC_ASSERT_NOW(a_trans_dense, out_valid && transition, pattern == PAT_DENSE && weight == WGT_DENSE)
	// local window pattern carries its own weight and no transition
	`SCRC_ASSERT_NOW(a_local_wgt, out_valid && pattern == PAT_LOCAL, weight == WGT_LOCAL && !transition)
	// every element transaction is followed by a busy cycle
	`SCRC_ASSERT_NEXT(a_elem_gap, in_valid && in_ready, !in_ready)
endmodule

bind state_change_rate_classifier scrc_sva u_scrc_sva (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.diff_norm   (diff_norm),
	.volatility  (volatility),
	.transition  (transition),
	.pattern     (pattern),
	.weight      (weight)
);
